// ===== design/mmbt_pkg.sv =====
package mmbt_pkg;

    // MIDI byte codes used for classification
    localparam logic [7:0] RT_FIRST     = 8'hF8;
    localparam logic [7:0] SYS_FIRST    = 8'hF0;
    localparam logic [7:0] TUNE_REQUEST = 8'hF6;
    localparam logic [7:0] EOX_BYTE     = 8'hF7;

    localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
    localparam logic [7:0] ST_CTRL_CHG   = 8'hB0;
    localparam logic [7:0] ST_PROG_CHG   = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] ST_PITCH_BEND = 8'hE0;
    localparam logic [7:0] ST_QFRAME     = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;

    typedef enum logic [1:0] {
        LEN_NONE,
        LEN_ONE,
        LEN_TWO
    } data_len_t;

    typedef struct packed {
        logic [7:0] status;
        logic       data_seen;
        logic       prev_done;
    } track_state_t;

    localparam track_state_t TRACK_RESET = '{status: 8'h00, data_seen: 1'b0, prev_done: 1'b1};

    // Data bytes the latched status needs; none means the data is not tracked
    function automatic data_len_t data_len(input logic [7:0] st);
        data_len_t len;
        unique case (st) inside
            ST_PROG_CHG, ST_CHAN_PRESS, ST_QFRAME, ST_SONG_SEL:
                len = LEN_ONE;
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CTRL_CHG, ST_PITCH_BEND, ST_SONG_POS:
                len = LEN_TWO;
            default:
                len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

// ===== design/mmbt_step.sv =====
module mmbt_step
    import mmbt_pkg::*;
(
    input  logic [7:0]   in_byte,
    input  track_state_t cur,
    output track_state_t nxt,
    output logic         done
);

    data_len_t len;

    assign len = data_len(cur.status);

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        if (in_byte[7]) begin
            if (in_byte >= RT_FIRST) begin
                // real-time: repeat the last flag
                done = cur.prev_done;
            end else if (in_byte == TUNE_REQUEST || in_byte == EOX_BYTE) begin
                nxt.status = 8'h00;
                done       = 1'b1;
            end else begin
                nxt.status    = (in_byte >= SYS_FIRST) ? in_byte : {in_byte[7:4], 4'h0};
                nxt.data_seen = 1'b0;
            end
        end else begin
            unique case (len)
                LEN_ONE: begin
                    nxt.status = 8'h00;
                    done       = 1'b1;
                end
                LEN_TWO: begin
                    if (cur.data_seen) begin
                        nxt.status = 8'h00;
                        done       = 1'b1;
                    end else begin
                        nxt.data_seen = 1'b1;
                    end
                end
                default: begin
                    done = 1'b0;
                end
            endcase
        end
        nxt.prev_done = done;
    end

endmodule

// ===== design/midi_message_boundary_tracker.sv =====
// MIDI message boundary tracker. Each request carries one MIDI byte; the
// block returns it unchanged together with m_message_done, which is high when
// that byte completes a message (or, for a real-time byte, repeats the flag of
// the byte before), so a merger can tell when it may switch sources. The
// block takes one byte per cycle while the output is not stalled:
// classification and the tracking state update happen in one short
// combinational step between the input port and the result register, and a
// new request is taken in the same cycle the pending result leaves. Results
// are registered and appear in the cycle after acceptance. Running status is
// not supported: data bytes after a completed message are flagged low until
// a new status byte arrives. Reset leaves no message open with the flag high.
module midi_message_boundary_tracker
    import mmbt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_message_done
);

    track_state_t state_reg;
    track_state_t state_next;
    logic         done_next;
    logic         m_valid_reg;
    logic [7:0]   byte_reg;
    logic         done_reg;
    logic         accept;

    // Take a new request whenever the result slot is empty or draining now
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mmbt_step u_step (
        .in_byte (s_in_byte),
        .cur     (state_reg),
        .nxt     (state_next),
        .done    (done_next)
    );

    // Advance tracking state only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TRACK_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result register: hold while stalled, load on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_in_byte;
            done_reg <= done_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_message_done = done_reg;

    // A real-time byte repeats the flag left by the previous byte
    a_rt_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_in_byte >= RT_FIRST) |=> (done_reg == $past(state_reg.prev_done)))
        else $error("real-time byte did not repeat previous flag");

    // A status byte that opens a message never completes one
    a_status_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_in_byte[7] && s_in_byte < TUNE_REQUEST) |=> !done_reg)
        else $error("opening status byte flagged as message end");

    // Channel status is latched with its channel bits cleared
    a_chan_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.status[7:4] != 4'hF) |-> (state_reg.status[3:0] == 4'h0))
        else $error("latched channel status keeps channel bits");

    // An accepted request always produces a pending result
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request left no result");

    // The last flag is tracked exactly as delivered
    a_prev_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) |-> (state_reg.prev_done == done_reg))
        else $error("previous flag out of step with result");

endmodule
